// ===== rtl/core/calendar_date_stepper_macros.svh =====
// Assertion macros used by the top level of the calendar date stepper.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CALENDAR_DATE_STEPPER_MACROS_SVH
`define CALENDAR_DATE_STEPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cds_pkg.sv =====
// Shared types, constants and calendar helper functions for the date stepper.
// Used by the controller, the datapath and the top level; depends on nothing.
package cds_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;
  localparam longint unsigned MAX_STEP_DEF = 64'd65535;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int STEP_W   = 16;
  localparam int NUM_W    = 22;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int M400_W   = 9;
  localparam int QUOT_W   = 8;
  localparam int DOY_W    = 9;

  // Reciprocal of 100 scaled by 2**19; exact for every 14-bit dividend.
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = 27;
  localparam int P365_W      = 23;
  localparam int SUM_W       = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 3'd0,
    CMD_NEXT = 3'd1,
    CMD_PREV = 3'd2,
    CMD_ADD  = 3'd3,
    CMD_SUB  = 3'd4
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LOAD = 2'd1,
    STAT_LIMIT    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_DIV,
    ST_LOAD_CHK,
    ST_STEP,
    ST_NUM_MUL,
    ST_NUM_SUM,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_div;
    logic load_chk;
    logic step;
    logic num_mul;
    logic num_sum;
    logic out_write;
  } dp_cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic at_limit;
  } dp_stat_t;

  function automatic logic is_leap(input logic [M400_W-1:0] m400, input logic [1:0] ylo);
    logic century;
    century = (m400 == M400_W'(100)) || (m400 == M400_W'(200)) || (m400 == M400_W'(300));
    return (m400 == '0) || ((ylo == 2'd0) && !century);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    unique case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ===== rtl/core/cds_ctrl.sv =====
// Controller state machine of the calendar date stepper.
// Depends on cds_pkg; drives the datapath through cds_pkg::dp_cmd_t.
module cds_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic [cds_pkg::CMD_W-1:0]        in_cmd,
  output logic                             in_tready,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  input  cds_pkg::dp_stat_t                stat,
  output cds_pkg::dp_cmd_t                 cmd
);

  cds_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cds_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      cds_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          if (in_cmd == cds_pkg::CMD_LOAD) begin
            state_nxt = cds_pkg::ST_LOAD_DIV;
          end else if ((in_cmd == cds_pkg::CMD_NEXT) || (in_cmd == cds_pkg::CMD_PREV) ||
                       (in_cmd == cds_pkg::CMD_ADD) || (in_cmd == cds_pkg::CMD_SUB)) begin
            state_nxt = cds_pkg::ST_STEP;
          end else begin
            state_nxt = cds_pkg::ST_NUM_MUL;
          end
        end
      end
      cds_pkg::ST_LOAD_DIV: begin
        cmd.load_div = 1'b1;
        state_nxt    = cds_pkg::ST_LOAD_CHK;
      end
      cds_pkg::ST_LOAD_CHK: begin
        cmd.load_chk = 1'b1;
        state_nxt    = cds_pkg::ST_NUM_MUL;
      end
      cds_pkg::ST_STEP: begin
        if (stat.steps_zero) begin
          state_nxt = cds_pkg::ST_NUM_MUL;
        end else begin
          cmd.step = 1'b1;
          if (stat.at_limit) begin
            state_nxt = cds_pkg::ST_NUM_MUL;
          end
        end
      end
      cds_pkg::ST_NUM_MUL: begin
        cmd.num_mul = 1'b1;
        state_nxt   = cds_pkg::ST_NUM_SUM;
      end
      cds_pkg::ST_NUM_SUM: begin
        cmd.num_sum = 1'b1;
        state_nxt   = cds_pkg::ST_WRITE;
      end
      cds_pkg::ST_WRITE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_write = 1'b1;
          state_nxt     = cds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_write) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_tready  = (state_r == cds_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/core/cds_datapath.sv =====
// Datapath of the calendar date stepper: date registers, day stepper,
// shared reciprocal multiplier for division by 100, and the result register.
// Depends on cds_pkg.
module cds_datapath #(
  parameter int unsigned     MAX_YEAR = cds_pkg::MAX_YEAR_DEF,
  parameter longint unsigned MAX_STEP = cds_pkg::MAX_STEP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cds_pkg::dp_cmd_t                 cmd,
  output cds_pkg::dp_stat_t                stat,
  input  logic [cds_pkg::CMD_W-1:0]        in_cmd,
  input  logic [cds_pkg::DAY_W-1:0]        in_load_day,
  input  logic [cds_pkg::MONTH_W-1:0]      in_load_month,
  input  logic [cds_pkg::YEAR_W-1:0]       in_load_year,
  input  logic [cds_pkg::STEP_W-1:0]       in_step_count,
  output logic [cds_pkg::DAY_W-1:0]        out_day,
  output logic [cds_pkg::MONTH_W-1:0]      out_month,
  output logic [cds_pkg::YEAR_W-1:0]       out_year,
  output logic [cds_pkg::NUM_W-1:0]        out_day_number,
  output logic [cds_pkg::STATUS_W-1:0]     out_status
);

  localparam logic [cds_pkg::YEAR_W-1:0] YEAR_LIMIT = cds_pkg::YEAR_W'(MAX_YEAR);
  localparam logic [cds_pkg::STEP_W-1:0] STEP_LIMIT = cds_pkg::STEP_W'(MAX_STEP);

  logic [cds_pkg::DAY_W-1:0]    day_r, day_nxt;
  logic [cds_pkg::MONTH_W-1:0]  month_r, month_nxt;
  logic [cds_pkg::YEAR_W-1:0]   year_r, year_nxt;
  logic [cds_pkg::M400_W-1:0]   m400_r, m400_nxt;
  logic [cds_pkg::STEP_W-1:0]   steps_r, steps_nxt;
  logic [cds_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic [cds_pkg::CMD_W-1:0]    op_r;
  logic [cds_pkg::DAY_W-1:0]    ld_r;
  logic [cds_pkg::MONTH_W-1:0]  lm_r;
  logic [cds_pkg::YEAR_W-1:0]   ly_r;
  logic [cds_pkg::QUOT_W-1:0]   quot_r;
  logic [cds_pkg::P365_W-1:0]   p365_r;
  logic [cds_pkg::YEAR_W-1:0]   gyear_r;
  logic [cds_pkg::NUM_W-1:0]    num_r, num_nxt;

  logic [cds_pkg::DAY_W-1:0]    res_day_r;
  logic [cds_pkg::MONTH_W-1:0]  res_month_r;
  logic [cds_pkg::YEAR_W-1:0]   res_year_r;
  logic [cds_pkg::NUM_W-1:0]    res_num_r;
  logic [cds_pkg::STATUS_W-1:0] res_status_r;

  logic                         fwd;
  logic                         leap_cur;
  logic [cds_pkg::DAY_W-1:0]    len_cur;
  logic [cds_pkg::DAY_W-1:0]    len_prev;
  logic [cds_pkg::YEAR_W-1:0]   gyear;
  logic [cds_pkg::YEAR_W-1:0]   mul_a;
  logic [cds_pkg::PROD_W-1:0]   prod;
  logic [cds_pkg::STEP_W-1:0]   cnt_sat;

  logic [cds_pkg::M400_W-1:0]   ld_m400;
  logic                         ld_leap;
  logic                         ld_ok;

  logic [cds_pkg::DOY_W-1:0]    doy;
  logic [cds_pkg::SUM_W-1:0]    num_sum;

  assign fwd      = (op_r == cds_pkg::CMD_NEXT) || (op_r == cds_pkg::CMD_ADD);
  assign leap_cur = cds_pkg::is_leap(m400_r, year_r[1:0]);
  assign len_cur  = cds_pkg::month_len(month_r, leap_cur);
  assign len_prev = cds_pkg::month_len(month_r - 4'd1, leap_cur);
  assign gyear    = year_r - 14'd1;

  assign stat.steps_zero = (steps_r == '0);
  assign stat.at_limit   = fwd ? ((day_r >= len_cur) && (month_r == 4'd12) &&
                                  (year_r >= YEAR_LIMIT))
                               : ((day_r <= 5'd1) && (month_r <= 4'd1) && (year_r <= 14'd1));

  assign mul_a = cmd.load_div ? ly_r : gyear;
  assign prod  = cds_pkg::PROD_W'(mul_a) * cds_pkg::PROD_W'(cds_pkg::RECIP_100);

  always_comb begin
    if ({16'd0, in_step_count} > 32'(MAX_STEP)) begin
      cnt_sat = STEP_LIMIT;
    end else begin
      cnt_sat = in_step_count;
    end
  end

  assign ld_m400 = cds_pkg::M400_W'(ly_r - cds_pkg::YEAR_W'({quot_r >> 2} * 16'd400));
  assign ld_leap = cds_pkg::is_leap(ld_m400, ly_r[1:0]);
  assign ld_ok   = (ly_r >= 14'd1) && (ly_r <= YEAR_LIMIT) &&
                   (lm_r >= 4'd1) && (lm_r <= 4'd12) &&
                   (ld_r >= 5'd1) && (ld_r <= cds_pkg::month_len(lm_r, ld_leap));

  assign doy     = cds_pkg::days_before(month_r, leap_cur) + cds_pkg::DOY_W'(day_r);
  assign num_sum = cds_pkg::SUM_W'(p365_r)
                 + cds_pkg::SUM_W'(gyear_r >> 2)
                 - cds_pkg::SUM_W'(quot_r)
                 + cds_pkg::SUM_W'(quot_r >> 2)
                 + cds_pkg::SUM_W'(doy);
  assign num_nxt = num_sum[cds_pkg::NUM_W-1:0];

  always_comb begin
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    m400_nxt   = m400_r;
    steps_nxt  = steps_r;
    status_nxt = status_r;
    if (cmd.capture) begin
      status_nxt = cds_pkg::STAT_OK;
      if ((in_cmd == cds_pkg::CMD_NEXT) || (in_cmd == cds_pkg::CMD_PREV)) begin
        steps_nxt = 16'd1;
      end else if ((in_cmd == cds_pkg::CMD_ADD) || (in_cmd == cds_pkg::CMD_SUB)) begin
        steps_nxt = cnt_sat;
      end else begin
        steps_nxt = '0;
      end
    end else if (cmd.load_chk) begin
      if (ld_ok) begin
        day_nxt   = ld_r;
        month_nxt = lm_r;
        year_nxt  = ly_r;
        m400_nxt  = ld_m400;
      end else begin
        status_nxt = cds_pkg::STAT_BAD_LOAD;
      end
    end else if (cmd.step) begin
      if (stat.at_limit) begin
        status_nxt = cds_pkg::STAT_LIMIT;
        steps_nxt  = '0;
      end else begin
        steps_nxt = steps_r - 16'd1;
        if (fwd) begin
          if (day_r < len_cur) begin
            day_nxt = day_r + 5'd1;
          end else if (month_r < 4'd12) begin
            day_nxt   = 5'd1;
            month_nxt = month_r + 4'd1;
          end else begin
            day_nxt   = 5'd1;
            month_nxt = 4'd1;
            year_nxt  = year_r + 14'd1;
            m400_nxt  = (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
          end
        end else begin
          if (day_r > 5'd1) begin
            day_nxt = day_r - 5'd1;
          end else if (month_r > 4'd1) begin
            month_nxt = month_r - 4'd1;
            day_nxt   = len_prev;
          end else begin
            month_nxt = 4'd12;
            day_nxt   = 5'd31;
            year_nxt  = year_r - 14'd1;
            m400_nxt  = (m400_r == 9'd0) ? 9'd399 : m400_r - 9'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r    <= 5'd1;
      month_r  <= 4'd1;
      year_r   <= 14'd1;
      m400_r   <= 9'd1;
      steps_r  <= '0;
      status_r <= cds_pkg::STAT_OK;
    end else begin
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      m400_r   <= m400_nxt;
      steps_r  <= steps_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_cmd;
      ld_r <= in_load_day;
      lm_r <= in_load_month;
      ly_r <= in_load_year;
    end
    if (cmd.load_div || cmd.num_mul) begin
      quot_r <= cds_pkg::QUOT_W'(prod >> cds_pkg::RECIP_SHIFT);
    end
    if (cmd.num_mul) begin
      p365_r  <= cds_pkg::P365_W'(gyear) * cds_pkg::P365_W'(365);
      gyear_r <= gyear;
    end
    if (cmd.num_sum) begin
      num_r <= num_nxt;
    end
    if (cmd.out_write) begin
      res_day_r    <= day_r;
      res_month_r  <= month_r;
      res_year_r   <= year_r;
      res_num_r    <= num_r;
      res_status_r <= status_r;
    end
  end

  assign out_day        = res_day_r;
  assign out_month      = res_month_r;
  assign out_year       = res_year_r;
  assign out_day_number = res_num_r;
  assign out_status     = res_status_r;

endmodule

// ===== rtl/core/calendar_date_stepper.sv =====
// Gregorian calendar date stepper. It holds a date that starts at 1 January of
// year 1 and takes one request at a time: load a date, step one day forward or
// back, or step forward or back by a count of days. Every request returns one
// result with the current date, its day number counted from 1 January of year 1,
// and a status (ok, invalid load rejected, year limit reached). A load passes
// through the divide and check states, a stepping request through the stepping
// loop, which moves the date by one day per cycle, and an unused command skips
// both; every request then computes the day number and writes the result. The
// next request is accepted while the previous result still waits in the output
// register.
// Top level: stream ports, controller and datapath instances, assertions.
// Depends on cds_pkg, cds_ctrl, cds_datapath and calendar_date_stepper_macros.svh.
`include "calendar_date_stepper_macros.svh"

module calendar_date_stepper #(
  parameter int unsigned     MAX_YEAR = cds_pkg::MAX_YEAR_DEF,
  parameter longint unsigned MAX_STEP = cds_pkg::MAX_STEP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // load_day [4:0], load_month [8:5], load_year [22:9], step_count [38:23]
  input  logic [39:0] in_tdata,
  // cmd [2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // day_out [4:0], month_out [8:5], year_out [22:9], day_number [44:23]
  output logic [47:0] out_tdata,
  // status [1:0]
  output logic [1:0]  out_tuser
);

  cds_pkg::dp_cmd_t  dp_cmd;
  cds_pkg::dp_stat_t dp_stat;

  logic [cds_pkg::DAY_W-1:0]    res_day;
  logic [cds_pkg::MONTH_W-1:0]  res_month;
  logic [cds_pkg::YEAR_W-1:0]   res_year;
  logic [cds_pkg::NUM_W-1:0]    res_num;
  logic [cds_pkg::STATUS_W-1:0] res_status;

  cds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  cds_datapath #(
    .MAX_YEAR (MAX_YEAR),
    .MAX_STEP (MAX_STEP)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .in_cmd         (in_tuser),
    .in_load_day    (in_tdata[4:0]),
    .in_load_month  (in_tdata[8:5]),
    .in_load_year   (in_tdata[22:9]),
    .in_step_count  (in_tdata[38:23]),
    .out_day        (res_day),
    .out_month      (res_month),
    .out_year       (res_year),
    .out_day_number (res_num),
    .out_status     (res_status)
  );

  assign out_tdata = {3'b000, res_num, res_year, res_month, res_day};
  assign out_tuser = res_status;

  `CDS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "request accepted while busy")
  `CDS_ASSERT_IMPLY(a_month_range, out_tvalid, (res_month >= 4'd1) && (res_month <= 4'd12), "result month out of range")
  `CDS_ASSERT_IMPLY(a_day_range, out_tvalid, (res_day >= 5'd1) && (res_day <= 5'd31), "result day out of range")
  `CDS_ASSERT_IMPLY(a_limit_date, out_tvalid && (res_status == cds_pkg::STAT_LIMIT), ((res_day == 5'd31) && (res_month == 4'd12) && (res_year == cds_pkg::YEAR_W'(MAX_YEAR))) || ((res_day == 5'd1) && (res_month == 4'd1) && (res_year == 14'd1)), "limit status away from a limit date")

endmodule
